[hdl/spp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spp_pkg: shared types and constants of the star perspective projector
// Widths of the divider datapath, register indexes and the side-band record
// that travels with each star through the pipeline.
// ----------------------------------------------------------------------------
package spp_pkg;

    localparam int NUM_W      = 40;   // |x| * 256 needs 40 bits
    localparam int DEN_W      = 28;   // positive depth below 2**28
    localparam int DIV_STAGES = NUM_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int CTR_W      = 42;   // signed width of centers and bounds

    localparam logic [CFG_IDX_W-1:0] REG_BASE_RADIUS   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUBPIXEL_MODE = 4'd3;

    localparam logic [23:0] RADIUS_MIN_FIXED = 24'd32;
    localparam logic signed [CTR_W-1:0] SCREEN_MAX = 42'sd2097151;
    localparam logic signed [CTR_W-1:0] SCREEN_MIN = -42'sd2097152;

    typedef struct packed {
        logic valid;
        logic depth_ok;
        logic x_neg;
        logic y_neg;
        logic final_star;
    } side_t;

endpackage
`default_nettype wire

[hdl/star_perspective_projector_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// star_perspective_projector_unit: perspective projection of star positions
// Divides x, y and the base radius by depth and tests the circle against
// the screen rectangle.
// ----------------------------------------------------------------------------
// Each star passes from input transfer to result through one input stage,
// 40 stages of the three bit-per-stage dividers (one stage per quotient bit
// of the 40-bit numerator), and one output stage. A new star is taken every
// cycle; the whole pipeline holds together while a result waits under
// out_stall, so in_stall simply mirrors a held output. Configuration is
// written through cfg_valid/cfg_ready (always ready) and must only change
// while no star is in flight; indexes beyond subpixel_mode are ignored.
// ----------------------------------------------------------------------------
module star_perspective_projector_unit
    import spp_pkg::*;
(
    input  wire                     clk,
    input  wire                     rst_n,
    // configuration
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire  [CFG_IDX_W-1:0]    cfg_index,
    input  wire  [CFG_DATA_W-1:0]   cfg_data,
    // star input
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire  signed [31:0]      star_x,
    input  wire  signed [28:0]      star_y,
    input  wire  signed [28:0]      star_z,
    input  wire                     final_star,
    // projected result
    output logic                    out_valid,
    input  wire                     out_stall,
    output logic                    visible,
    output logic signed [21:0]      screen_x,
    output logic signed [21:0]      screen_y,
    output logic [23:0]             draw_radius,
    output logic                    exact_draw,
    output logic                    frame_end
);

    // configuration registers
    logic [23:0] base_radius_reg;
    logic [11:0] screen_width_reg;
    logic [11:0] screen_height_reg;
    logic        subpixel_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_radius_reg   <= 24'd256;
            screen_width_reg  <= 12'd640;
            screen_height_reg <= 12'd480;
            subpixel_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BASE_RADIUS:   base_radius_reg   <= cfg_data;
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[11:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[11:0];
                REG_SUBPIXEL_MODE: subpixel_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // advance everything unless a finished result is held
    logic adv;
    logic out_valid_reg;
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // input stage: magnitudes of the numerators, positive divisor
    logic [NUM_W-1:0] numx_reg, numy_reg, numr_reg;
    logic [DEN_W-1:0] den_reg;
    side_t            side_reg [0:DIV_STAGES];

    logic [NUM_W-1:0] numx_next, numy_next, numr_next;
    logic [DEN_W-1:0] den_next;
    side_t            side0_next;
    logic [32:0]      absx;
    logic [29:0]      absy;

    always_comb
    begin
        absx = star_x[31] ? 33'(-$signed({star_x[31], star_x})) : {1'b0, star_x};
        absy = star_y[28] ? 30'(-$signed({star_y[28], star_y})) : {1'b0, star_y};
        numx_next = NUM_W'({absx, 8'b0});
        numy_next = NUM_W'({absy, 8'b0});
        numr_next = NUM_W'({base_radius_reg, 4'b0});
        side0_next.valid      = in_valid;
        side0_next.depth_ok   = (star_z > 29'sd16);
        side0_next.x_neg      = star_x[31];
        side0_next.y_neg      = star_y[28];
        side0_next.final_star = final_star;
        // drop nonsensical divisors; the result is masked anyway
        den_next = side0_next.depth_ok ? star_z[DEN_W-1:0] : DEN_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            numx_reg <= numx_next;
            numy_reg <= numy_next;
            numr_reg <= numr_next;
            den_reg  <= den_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else if (adv)
        begin
            side_reg[0] <= side0_next;
            for (int k = 1; k <= DIV_STAGES; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // three dividers share the depth divisor
    logic [NUM_W-1:0] qx, qy, qr;

    spp_divider u_div_x (.clk(clk), .en(adv), .num_in(numx_reg), .den_in(den_reg), .quo(qx));
    spp_divider u_div_y (.clk(clk), .en(adv), .num_in(numy_reg), .den_in(den_reg), .quo(qy));
    spp_divider u_div_r (.clk(clk), .en(adv), .num_in(numr_reg), .den_in(den_reg), .quo(qr));

    // output stage: restore signs, center, overlap test, saturate
    side_t                   side_out;
    logic signed [CTR_W-1:0] cx, cy, rs, wb, hb;
    logic                    vis_next;
    logic signed [CTR_W-1:0] sx_sat, sy_sat;

    always_comb
    begin
        side_out = side_reg[DIV_STAGES];
        rs = $signed({18'b0, qr[23:0]});
        wb = $signed({22'b0, screen_width_reg, 8'b0});
        hb = $signed({22'b0, screen_height_reg, 8'b0});
        cx = side_out.x_neg ? -$signed({2'b0, qx}) : $signed({2'b0, qx});
        cy = side_out.y_neg ? -$signed({2'b0, qy}) : $signed({2'b0, qy});
        cx = cx + $signed({23'b0, screen_width_reg[11:1], 8'b0});
        cy = cy + $signed({23'b0, screen_height_reg[11:1], 8'b0});
        vis_next = side_out.depth_ok && (qr[23:0] > RADIUS_MIN_FIXED)
                   && (cx > -rs) && ((cx - rs) < wb)
                   && (cy > -rs) && ((cy - rs) < hb);
        sx_sat = (cx > SCREEN_MAX) ? SCREEN_MAX : ((cx < SCREEN_MIN) ? SCREEN_MIN : cx);
        sy_sat = (cy > SCREEN_MAX) ? SCREEN_MAX : ((cy < SCREEN_MIN) ? SCREEN_MIN : cy);
    end

    logic                visible_reg, exact_draw_reg, frame_end_reg;
    logic signed [21:0]  screen_x_reg, screen_y_reg;
    logic [23:0]         draw_radius_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= side_out.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            visible_reg     <= vis_next;
            screen_x_reg    <= vis_next ? sx_sat[21:0] : 22'sd0;
            screen_y_reg    <= vis_next ? sy_sat[21:0] : 22'sd0;
            draw_radius_reg <= vis_next ? qr[23:0] : 24'd0;
            exact_draw_reg  <= subpixel_mode_reg;
            frame_end_reg   <= side_out.final_star;
        end
    end

    assign out_valid   = out_valid_reg;
    assign visible     = visible_reg;
    assign screen_x    = screen_x_reg;
    assign screen_y    = screen_y_reg;
    assign draw_radius = draw_radius_reg;
    assign exact_draw  = exact_draw_reg;
    assign frame_end   = frame_end_reg;

`ifndef SYNTHESIS
    a_vis_radius: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && visible |-> draw_radius > RADIUS_MIN_FIXED)
        else $error("visible star with radius at or below 1/8");
    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !visible |-> screen_x == 0 && screen_y == 0 && draw_radius == 0)
        else $error("hidden star carries nonzero fields");
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> side_reg[0].valid)
        else $error("accepted star not captured");
`endif

endmodule
`default_nettype wire

[hdl/spp_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// spp_divider: pipelined unsigned restoring divider
// One quotient bit per stage; the whole chain advances on en.
// ----------------------------------------------------------------------------
module spp_divider
    import spp_pkg::*;
(
    input  wire                    clk,
    input  wire                    en,
    input  wire  [NUM_W-1:0]       num_in,
    input  wire  [DEN_W-1:0]       den_in,
    output logic [NUM_W-1:0]       quo
);

    logic [NUM_W-1:0] nq_reg  [0:DIV_STAGES-1];
    logic [DEN_W-1:0] rem_reg [0:DIV_STAGES-1];
    logic [DEN_W-1:0] den_reg [0:DIV_STAGES-1];

    genvar i;
    generate
        for (i = 0; i < DIV_STAGES; i++)
        begin : g_stage
            logic [NUM_W-1:0] nq_prev;
            logic [DEN_W-1:0] rem_prev;
            logic [DEN_W-1:0] den_prev;
            logic [DEN_W:0]   trial;
            logic             ge;
            logic [NUM_W-1:0] nq_next;
            logic [DEN_W-1:0] rem_next;

            if (i == 0)
            begin : g_first
                assign nq_prev  = num_in;
                assign rem_prev = '0;
                assign den_prev = den_in;
            end
            else
            begin : g_rest
                assign nq_prev  = nq_reg[i-1];
                assign rem_prev = rem_reg[i-1];
                assign den_prev = den_reg[i-1];
            end

            always_comb
            begin
                trial    = {rem_prev, nq_prev[NUM_W-1]};
                ge       = (trial >= {1'b0, den_prev});
                rem_next = ge ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
                nq_next  = {nq_prev[NUM_W-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nq_reg[i]  <= nq_next;
                    rem_reg[i] <= rem_next;
                    den_reg[i] <= den_prev;
                end
            end
        end
    endgenerate

    assign quo = nq_reg[DIV_STAGES-1];

endmodule
`default_nettype wire
